@@ src/semaphore_set_table_macros.svh @@
// ----------------------------------------------------------------------------
// semaphore set table assertion macros
// shorthand for clocked, reset-qualified concurrent checks
// ----------------------------------------------------------------------------
`ifndef SEMAPHORE_SET_TABLE_MACROS_SVH
`define SEMAPHORE_SET_TABLE_MACROS_SVH

// same-cycle implication
`define SST_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SST_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// sizes, command and status codes of the semaphore set table
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int NUM_SETS      = 32;
   localparam int SEMS_PER_SET  = 64;
   localparam int MAX_GROUP_OPS = 32;

   localparam int SET_W   = $clog2(NUM_SETS);
   localparam int SEM_W   = $clog2(SEMS_PER_SET);
   localparam int ADDR_W  = SET_W + SEM_W;
   localparam int SIZE_W  = $clog2(SEMS_PER_SET + 1);
   localparam int COUNT_W = $clog2(MAX_GROUP_OPS + 1);

   localparam logic [2:0] CMD_GET     = 3'd0;
   localparam logic [2:0] CMD_OP      = 3'd1;
   localparam logic [2:0] CMD_REMOVE  = 3'd2;
   localparam logic [2:0] CMD_GET_VAL = 3'd3;
   localparam logic [2:0] CMD_SET_VAL = 3'd4;
   localparam logic [2:0] CMD_GET_PID = 3'd5;
   localparam logic [2:0] CMD_WAITERS = 3'd6;
   localparam logic [2:0] CMD_BAD     = 3'd7;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_INVALID     = 3'd1;
   localparam logic [2:0] ST_EXISTS      = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
   localparam logic [2:0] ST_NO_SPACE    = 3'd4;
   localparam logic [2:0] ST_TOO_BIG     = 3'd5;
   localparam logic [2:0] ST_WOULD_BLOCK = 3'd6;

   typedef logic [2:0] status_type;

   function automatic logic [1:0] err_rank(input status_type code);
      logic [1:0] r;
      case (code)
         ST_INVALID:     r = 2'd3;
         ST_TOO_BIG:     r = 2'd2;
         ST_WOULD_BLOCK: r = 2'd1;
         default:        r = 2'd0;
      endcase
      return r;
   endfunction

   // keep the higher-priority group error
   function automatic status_type raise_err(input status_type cur, input status_type code);
      status_type r;
      r = (err_rank(code) > err_rank(cur)) ? code : cur;
      return r;
   endfunction

endpackage

@@ src/sst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module sst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ src/semaphore_set_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semaphore_set_table
// table of semaphore sets with key lookup, atomic operation groups and control
// ----------------------------------------------------------------------------
// One request word is taken at a time; req_tready is high only while the
// sequencer is idle. A get scans the set table one entry at a time (a read
// state, then a compare state, as the key memory read is registered) and,
// when it creates a set, zeroes one semaphore per cycle (1 to 64 of them).
// The operation element that closes a group also walks all 64 staged slots,
// a read state then a write state for each, to write back value and pid
// through the write ports of the value and pid memories. Every request except
// a non-closing operation element gives exactly one response word, held in an
// output register until rsp_tready. There is no clearing pass after reset:
// only the sequencer state, the response valid flag, the set-in-use flags,
// the free-slot flag and the group state are reset.
// ----------------------------------------------------------------------------
`include "semaphore_set_table_macros.svh"

module semaphore_set_table
   import sst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // set_index[4:0] key[36:5] create_flag[37] exclusive_flag[38]
   // count_requested[45:39] sem_index[61:46] sem_change[77:62]
   // new_value[93:78] caller_pid[124:94] zero[127:125]
   input  logic [127:0] req_tdata,
   // command[2:0]
   input  logic [2:0]   req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // set_result[4:0] value_read[20:5] pid_read[51:21] zero[55:52]
   output logic [55:0]  rsp_tdata,
   // status[2:0]
   output logic [2:0]   rsp_tuser
);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_GRD   = 4'd2;
   localparam logic [3:0] S_GCMP  = 4'd3;
   localparam logic [3:0] S_CLR   = 4'd4;
   localparam logic [3:0] S_OP1   = 4'd5;
   localparam logic [3:0] S_OP2   = 4'd6;
   localparam logic [3:0] S_OPEND = 4'd7;
   localparam logic [3:0] S_CWRD  = 4'd8;
   localparam logic [3:0] S_CWWR  = 4'd9;
   localparam logic [3:0] S_CT1   = 4'd10;
   localparam logic [3:0] S_CT2   = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   localparam logic [SET_W-1:0]   LAST_SET  = SET_W'(NUM_SETS - 1);
   localparam logic [SEM_W-1:0]   LAST_SEM  = SEM_W'(SEMS_PER_SET - 1);
   localparam logic [15:0]        SEMS_16   = 16'(SEMS_PER_SET);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_GROUP_OPS);

   // control state
   logic [3:0]              state_ff, state_in;
   logic [NUM_SETS-1:0]     in_use_ff, in_use_in;
   logic [SEMS_PER_SET-1:0] mask_ff, mask_in;
   logic [COUNT_W-1:0]      gcount_ff, gcount_in;
   logic [SET_W-1:0]        gset_ff, gset_in;
   status_type              gerr_ff, gerr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    free_ok_ff, free_ok_in;

   // latched request word
   logic [2:0]        cmd_ff;
   logic [SET_W-1:0]  sidx_ff;
   logic [31:0]       key_ff;
   logic              cr_ff, ex_ff, last_ff;
   logic [6:0]        cnt_ff;
   logic [15:0]       semi_ff, chg_ff, nv_ff;
   logic [30:0]       pid_ff;

   // walk counters and pending result
   logic [SET_W-1:0]  scan_ff, scan_in;
   logic [SET_W-1:0]  free_ff, free_in;
   logic [SEM_W-1:0]  walk_ff, walk_in;
   status_type        st_ff, st_in;
   logic [SET_W-1:0]  res_ff, res_in;
   logic [15:0]       val_ff, val_in;
   logic [30:0]       rpid_ff, rpid_in;

   // response register
   status_type        rsp_st_ff;
   logic [SET_W-1:0]  rsp_res_ff;
   logic [15:0]       rsp_val_ff;
   logic [30:0]       rsp_pid_ff;

   // memory ports
   logic              key_we;
   logic [31:0]       key_rd;
   logic              size_we;
   logic [SET_W-1:0]  size_raddr;
   logic [SIZE_W-1:0] size_wdata, size_rd;
   logic              val_we;
   logic [ADDR_W-1:0] val_waddr, val_raddr;
   logic [15:0]       val_wdata, val_rd;
   logic              pidm_we;
   logic [30:0]       pidm_wdata, pidm_rd;
   logic              stg_we;
   logic [SEM_W-1:0]  stg_raddr;
   logic [15:0]       stg_wdata, stg_rd;

   logic              accept;
   logic [SEM_W-1:0]  semj;
   logic [SET_W-1:0]  gset_eff;
   logic [SIZE_W-1:0] cnt_eff;
   logic              sem_oob;
   logic [15:0]       cur_v;
   logic [16:0]       sum17;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign semj       = semi_ff[SEM_W-1:0];
   assign gset_eff   = (gcount_ff == '0) ? sidx_ff : gset_ff;
   assign cnt_eff    = (cnt_ff == 7'd0) ? SIZE_W'(1) : SIZE_W'(cnt_ff);
   assign sem_oob    = (semi_ff >= {{(16 - SIZE_W){1'b0}}, size_rd}) || (semi_ff >= SEMS_16);
   assign cur_v      = mask_ff[semj] ? stg_rd : val_rd;
   assign sum17      = {cur_v[15], cur_v} + {chg_ff[15], chg_ff};

   assign size_raddr = (state_ff == S_DISP && cmd_ff == CMD_OP) ? gset_eff : sidx_ff;
   assign val_raddr  = (state_ff == S_OP1) ? {gset_ff, semj} : {sidx_ff, semj};
   assign stg_raddr  = (state_ff == S_CWRD) ? walk_ff : semj;

   sst_ram #(.WIDTH(32), .DEPTH(NUM_SETS)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(free_in), .wr_data(key_ff),
      .rd_addr(scan_ff), .rd_data(key_rd)
   );

   sst_ram #(.WIDTH(SIZE_W), .DEPTH(NUM_SETS)) u_size (
      .clock(clock), .wr_en(size_we), .wr_addr(free_in), .wr_data(size_wdata),
      .rd_addr(size_raddr), .rd_data(size_rd)
   );

   sst_ram #(.WIDTH(16), .DEPTH(NUM_SETS * SEMS_PER_SET)) u_value (
      .clock(clock), .wr_en(val_we), .wr_addr(val_waddr), .wr_data(val_wdata),
      .rd_addr(val_raddr), .rd_data(val_rd)
   );

   sst_ram #(.WIDTH(31), .DEPTH(NUM_SETS * SEMS_PER_SET)) u_pid (
      .clock(clock), .wr_en(pidm_we), .wr_addr(val_waddr), .wr_data(pidm_wdata),
      .rd_addr(val_raddr), .rd_data(pidm_rd)
   );

   sst_ram #(.WIDTH(16), .DEPTH(SEMS_PER_SET)) u_stage (
      .clock(clock), .wr_en(stg_we), .wr_addr(semj), .wr_data(stg_wdata),
      .rd_addr(stg_raddr), .rd_data(stg_rd)
   );

   // sequencer
   always_comb begin
      status_type e;
      logic       hit;
      state_in     = state_ff;
      in_use_in    = in_use_ff;
      mask_in      = mask_ff;
      gcount_in    = gcount_ff;
      gset_in      = gset_ff;
      gerr_in      = gerr_ff;
      free_ok_in   = free_ok_ff;
      free_in      = free_ff;
      scan_in      = scan_ff;
      walk_in      = walk_ff;
      st_in        = st_ff;
      res_in       = res_ff;
      val_in       = val_ff;
      rpid_in      = rpid_ff;
      rsp_valid_in = rsp_valid_ff;
      key_we       = 1'b0;
      size_we      = 1'b0;
      size_wdata   = cnt_eff;
      val_we       = 1'b0;
      pidm_we      = 1'b0;
      val_waddr    = {sidx_ff, semj};
      val_wdata    = nv_ff;
      pidm_wdata   = pid_ff;
      stg_we       = 1'b0;
      stg_wdata    = cur_v;
      e            = gerr_ff;
      hit          = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            st_in   = ST_OK;
            res_in  = '0;
            val_in  = '0;
            rpid_in = '0;
            if (cmd_ff == CMD_GET) begin
               if (cnt_ff > 7'(SEMS_PER_SET)) begin
                  st_in    = ST_INVALID;
                  state_in = S_DONE;
               end else begin
                  scan_in    = '0;
                  free_ok_in = 1'b0;
                  state_in   = S_GRD;
               end
            end else if (cmd_ff == CMD_OP) begin
               gset_in = gset_eff;
               if (gcount_ff >= MAX_COUNT) begin
                  e = raise_err(e, ST_INVALID);
               end else begin
                  gcount_in = gcount_ff + COUNT_W'(1);
               end
               if (!in_use_ff[gset_eff]) begin
                  e        = raise_err(e, ST_INVALID);
                  state_in = S_OPEND;
               end else begin
                  state_in = S_OP1;
               end
               gerr_in = e;
            end else if (cmd_ff == CMD_BAD || !in_use_ff[sidx_ff]) begin
               st_in    = ST_INVALID;
               state_in = S_DONE;
            end else if (cmd_ff == CMD_REMOVE) begin
               in_use_in[sidx_ff] = 1'b0;
               state_in           = S_DONE;
            end else begin
               state_in = S_CT1;
            end
         end
         S_GRD: begin
            state_in = S_GCMP;
         end
         S_GCMP: begin
            hit = (key_ff != 32'd0) && in_use_ff[scan_ff] && (key_rd == key_ff);
            if (!in_use_ff[scan_ff] && !free_ok_ff) begin
               free_ok_in = 1'b1;
               free_in    = scan_ff;
            end
            if (hit) begin
               if (cr_ff && ex_ff) begin
                  st_in = ST_EXISTS;
               end else begin
                  res_in = scan_ff;
               end
               state_in = S_DONE;
            end else if (scan_ff == LAST_SET) begin
               if (key_ff != 32'd0 && !cr_ff) begin
                  st_in    = ST_NOT_FOUND;
                  state_in = S_DONE;
               end else if (free_ok_in) begin
                  in_use_in[free_in] = 1'b1;
                  key_we   = 1'b1;
                  size_we  = 1'b1;
                  walk_in  = '0;
                  state_in = S_CLR;
               end else begin
                  st_in    = ST_NO_SPACE;
                  state_in = S_DONE;
               end
            end else begin
               scan_in  = scan_ff + SET_W'(1);
               state_in = S_GRD;
            end
         end
         S_CLR: begin
            val_we     = 1'b1;
            pidm_we    = 1'b1;
            val_waddr  = {free_ff, walk_ff};
            val_wdata  = '0;
            pidm_wdata = '0;
            walk_in    = walk_ff + SEM_W'(1);
            if (walk_ff == SEM_W'(cnt_eff - SIZE_W'(1))) begin
               res_in   = free_ff;
               state_in = S_DONE;
            end
         end
         S_OP1: begin
            if (sem_oob) begin
               gerr_in  = raise_err(gerr_ff, ST_TOO_BIG);
               state_in = S_OPEND;
            end else if (gerr_ff != ST_OK) begin
               state_in = S_OPEND;
            end else begin
               state_in = S_OP2;
            end
         end
         S_OP2: begin
            stg_we        = 1'b1;
            mask_in[semj] = 1'b1;
            if (!chg_ff[15] && chg_ff != 16'd0) begin
               stg_wdata = sum17[15:0];
            end else if (chg_ff[15]) begin
               if (sum17[16]) begin
                  gerr_in = raise_err(gerr_ff, ST_WOULD_BLOCK);
               end else begin
                  stg_wdata = sum17[15:0];
               end
            end else if (cur_v != 16'd0) begin
               gerr_in = raise_err(gerr_ff, ST_WOULD_BLOCK);
            end
            state_in = S_OPEND;
         end
         S_OPEND: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else begin
               if (gerr_ff == ST_OK && !in_use_ff[gset_ff]) begin
                  e = raise_err(e, ST_INVALID);
               end
               if (e == ST_OK) begin
                  walk_in  = '0;
                  state_in = S_CWRD;
               end else begin
                  st_in     = e;
                  mask_in   = '0;
                  gcount_in = '0;
                  gset_in   = '0;
                  gerr_in   = ST_OK;
                  state_in  = S_DONE;
               end
            end
         end
         S_CWRD: begin
            state_in = S_CWWR;
         end
         S_CWWR: begin
            val_waddr = {gset_ff, walk_ff};
            val_wdata = stg_rd;
            val_we    = mask_ff[walk_ff];
            pidm_we   = mask_ff[walk_ff];
            walk_in   = walk_ff + SEM_W'(1);
            if (walk_ff == LAST_SEM) begin
               mask_in   = '0;
               gcount_in = '0;
               gset_in   = '0;
               gerr_in   = ST_OK;
               state_in  = S_DONE;
            end else begin
               state_in = S_CWRD;
            end
         end
         S_CT1: begin
            if (sem_oob) begin
               st_in    = ST_INVALID;
               state_in = S_DONE;
            end else begin
               case (cmd_ff)
                  CMD_GET_VAL, CMD_GET_PID: state_in = S_CT2;
                  CMD_SET_VAL: begin
                     val_we   = 1'b1;
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CT2: begin
            if (cmd_ff == CMD_GET_VAL) begin
               val_in = val_rd;
            end else begin
               rpid_in = pidm_rd;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_use_ff    <= '0;
         mask_ff      <= '0;
         gcount_ff    <= '0;
         gset_ff      <= '0;
         gerr_ff      <= ST_OK;
         rsp_valid_ff <= 1'b0;
         free_ok_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         mask_ff      <= mask_in;
         gcount_ff    <= gcount_in;
         gset_ff      <= gset_in;
         gerr_ff      <= gerr_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ok_ff   <= free_ok_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_tuser;
         sidx_ff <= req_tdata[4:0];
         key_ff  <= req_tdata[36:5];
         cr_ff   <= req_tdata[37];
         ex_ff   <= req_tdata[38];
         cnt_ff  <= req_tdata[45:39];
         semi_ff <= req_tdata[61:46];
         chg_ff  <= req_tdata[77:62];
         nv_ff   <= req_tdata[93:78];
         pid_ff  <= req_tdata[124:94];
         last_ff <= req_tlast;
      end
      scan_ff <= scan_in;
      free_ff <= free_in;
      walk_ff <= walk_in;
      st_ff   <= st_in;
      res_ff  <= res_in;
      val_ff  <= val_in;
      rpid_ff <= rpid_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_st_ff  <= st_ff;
         rsp_res_ff <= res_ff;
         rsp_val_ff <= val_ff;
         rsp_pid_ff <= rpid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {4'd0, rsp_pid_ff, rsp_val_ff, rsp_res_ff};

   // checks
   `SST_ASSERT_IMP(a_count_cap, 1'b1, gcount_ff <= MAX_COUNT, "group count past limit")
   `SST_ASSERT_IMP(a_idle_group, gcount_ff == '0, mask_ff == '0 && gerr_ff == ST_OK,
                   "group state left over with no open group")
   `SST_ASSERT_IMP(a_commit_clean, state_ff == S_CWRD || state_ff == S_CWWR,
                   gerr_ff == ST_OK, "commit walk with a group error")
   `SST_ASSERT_NXT(a_accept_disp, accept, state_ff == S_DISP, "accepted word not dispatched")

endmodule
